[sv/styled_dda_line_stepper_unit_defines.svh]
// Assertion macros shared by the line stepper modules.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef STYLED_DDA_LINE_STEPPER_UNIT_DEFINES_SVH
`define STYLED_DDA_LINE_STEPPER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define SDLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define SDLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sdls_pkg.sv]
// Shared constants, register codes and control structs for the line stepper.
// Depends on nothing; imported by all files but the macro header.
package sdls_pkg;

   // Default geometry
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;

   // Configuration register widths and reset values
   localparam int STYLE_BITS = 2;
   localparam int DOT_BITS   = 5;
   localparam int DASH_BITS  = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [DOT_BITS-1:0]  DOT_PERIOD_RST  = DOT_BITS'(20);
   localparam logic [DASH_BITS-1:0] DASH_PERIOD_RST = DASH_BITS'(15);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STYLE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOT_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DASH_PERIOD = 2'd2;

   // Line style codes
   localparam logic [STYLE_BITS-1:0] STYLE_SIMPLE = 2'd0;
   localparam logic [STYLE_BITS-1:0] STYLE_DOTTED = 2'd1;
   localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 2'd2;
   localparam logic [STYLE_BITS-1:0] STYLE_THICK  = 2'd3;

   // Action codes of an input word
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic start;       // load a new line, emit its start pixel
      logic step;        // advance one step or report an idle step
      logic out_load;    // capture a result word
      logic div_step;    // one restoring division iteration on both lanes
      logic div_finish;  // apply signs and store increments
   } sdls_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic len_zero;    // start word has equal endpoints
   } sdls_status_type;

endpackage

[sv/sdls_if.sv]
// Handshake channel interfaces: request, response and register write.
// Depends on sdls_pkg for default widths and register field sizes.
interface sdls_req_if import sdls_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic valid;
   logic ready;
   logic action;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;

   modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

interface sdls_rsp_if import sdls_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic plotted;
   logic wide_point;
   logic last_pixel;
   logic idle_step;

   modport source (output valid, pixel_x, pixel_y, plotted, wide_point, last_pixel,
                   idle_step, input ready);
   modport sink   (input valid, pixel_x, pixel_y, plotted, wide_point, last_pixel,
                   idle_step, output ready);
endinterface

interface sdls_csr_if import sdls_pkg::*;;
   logic valid;
   logic ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/sdls_ctrl.sv]
// Controller: request acceptance, result register valid and divider sequencing.
// Depends on sdls_pkg and the assertion macro header.
`include "styled_dda_line_stepper_unit_defines.svh"

module sdls_ctrl import sdls_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_action,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   input  sdls_status_type status,
   output sdls_cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;
   logic                accept;

   // Accept only in idle out of reset, if the result word is empty or taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Issue commands
   always_comb begin
      cmd.start      = accept && (req_action == ACT_START);
      cmd.step       = accept && (req_action == ACT_STEP);
      cmd.out_load   = accept;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.div_finish = (state_ff == ST_FIN);
   end

   // Sequence the divider: one quotient bit per cycle, then the finish state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start && !status.len_zero) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Hold a result word until taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SDLS_ASSERT_NXT(a_start_divides, clock, reset, cmd.start && !status.len_zero,
      state_ff == ST_DIV && cnt_ff == '0, "line start did not enter division")
   `SDLS_ASSERT_IMP(a_busy_blocks, clock, reset, state_ff != ST_IDLE, !req_ready,
      "request taken while dividing")
   `SDLS_ASSERT_IMP(a_idle_count, clock, reset, state_ff == ST_IDLE, cnt_ff == '0,
      "iteration count not cleared in idle")
   `SDLS_ASSERT_IMP(a_finish_order, clock, reset, state_ff == ST_FIN,
      $past(state_ff) == ST_DIV && $past(cnt_ff) == CNT_LAST,
      "finish reached without full division")

endmodule

[sv/sdls_datapath.sv]
// Datapath: config registers, line setup, two-lane restoring divider,
// accumulators, style counters and the result register. Depends on sdls_pkg.
module sdls_datapath import sdls_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sdls_cmd_type                 cmd,
   output sdls_status_type              status,
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data,
   output logic signed [COORD_BITS-1:0] pixel_x,
   output logic signed [COORD_BITS-1:0] pixel_y,
   output logic                         plotted,
   output logic                         wide_point,
   output logic                         last_pixel,
   output logic                         idle_step
);

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int NUM_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_BITS  = FRAC_BITS + 2;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS = COORD_BITS + 1;
   localparam logic [ACC_BITS-1:0] HALF_LSB =
      {{(ACC_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   // Pixel of an accumulator, truncated toward zero
   function automatic logic [COORD_BITS-1:0] trunc_pix(input logic [ACC_BITS-1:0] a);
      logic [COORD_BITS:0] whole;
      logic [COORD_BITS:0] sum;
      logic                bump;
      whole = a[ACC_BITS-1:FRAC_BITS];
      bump  = a[ACC_BITS-1] & (|a[FRAC_BITS-1:0]);
      sum   = whole + {{COORD_BITS{1'b0}}, bump};
      return sum[COORD_BITS-1:0];
   endfunction

   // Configuration
   logic [STYLE_BITS-1:0] style_ff;
   logic [DOT_BITS-1:0]   dot_per_ff;
   logic [DASH_BITS-1:0]  dash_per_ff;

   // Line state
   logic [ACC_BITS-1:0]  acc_x_ff, acc_y_ff;
   logic [INC_BITS-1:0]  inc_x_ff, inc_y_ff;
   logic [STEP_BITS-1:0] idx_ff, total_ff;
   logic [DOT_BITS-1:0]  dot_cnt_ff;
   logic [DASH_BITS-1:0] dash_cnt_ff;
   logic                 dash_off_ff;
   logic                 active_ff;

   // Divider state
   logic                  neg_x_ff, neg_y_ff;
   logic [COORD_BITS-1:0] rem_x_ff, rem_y_ff;
   logic [QUO_BITS-1:0]   quo_x_ff, quo_y_ff;

   // Result register
   logic [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic                  plot_ff, wide_ff, last_ff, idle_ff;

   // Setup signals
   logic [COORD_BITS:0]   dx, dy, mag_x, mag_y;
   logic [COORD_BITS-1:0] len_x, len_y, len;
   logic [NUM_BITS-1:0]   num_x, num_y;

   // Divider signals
   logic [COORD_BITS-1:0] divisor;
   logic [COORD_BITS:0]   trial_x, trial_y, diff_x, diff_y;
   logic                  ge_x, ge_y;

   // Step signals
   logic [ACC_BITS-1:0]   sum_x, sum_y, rnd_x, rnd_y, acc_next_x, acc_next_y;
   logic [COORD_BITS:0]   rpix_x, rpix_y;
   logic [COORD_BITS-1:0] step_pix_x, step_pix_y;
   logic [STEP_BITS-1:0]  idx_next;
   logic                  last_step;
   logic [DOT_BITS:0]     dot_sum;
   logic [DOT_BITS-1:0]   dot_lim;
   logic                  dot_hit;
   logic [DASH_BITS:0]    dash_sum;
   logic [DASH_BITS-1:0]  dash_lim;
   logic                  dash_wrap;
   logic                  dash_off_next;
   logic                  step_plot;

   // Line setup: deltas, span and rounded dividends
   always_comb begin
      dx    = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
      dy    = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
      mag_x = dx[COORD_BITS] ? -dx : dx;
      mag_y = dy[COORD_BITS] ? -dy : dy;
      len_x = mag_x[COORD_BITS-1:0];
      len_y = mag_y[COORD_BITS-1:0];
      len   = (len_x >= len_y) ? len_x : len_y;
      num_x = {1'b0, len_x, {FRAC_BITS{1'b0}}} + NUM_BITS'(len >> 1);
      num_y = {1'b0, len_y, {FRAC_BITS{1'b0}}} + NUM_BITS'(len >> 1);
      status.len_zero = (len == '0);
   end

   // Restoring division: shift one dividend bit in, subtract when it fits
   always_comb begin
      divisor = total_ff[COORD_BITS-1:0];
      trial_x = {rem_x_ff, quo_x_ff[QUO_BITS-1]};
      trial_y = {rem_y_ff, quo_y_ff[QUO_BITS-1]};
      diff_x  = trial_x - {1'b0, divisor};
      diff_y  = trial_y - {1'b0, divisor};
      ge_x    = trial_x >= {1'b0, divisor};
      ge_y    = trial_y >= {1'b0, divisor};
   end

   // Step: advance, snap to the nearest integer on the last step
   always_comb begin
      sum_x = acc_x_ff + {{(ACC_BITS-INC_BITS){inc_x_ff[INC_BITS-1]}}, inc_x_ff};
      sum_y = acc_y_ff + {{(ACC_BITS-INC_BITS){inc_y_ff[INC_BITS-1]}}, inc_y_ff};
      rnd_x = sum_x + HALF_LSB;
      rnd_y = sum_y + HALF_LSB;
      rpix_x = rnd_x[ACC_BITS-1:FRAC_BITS];
      rpix_y = rnd_y[ACC_BITS-1:FRAC_BITS];
      idx_next  = idx_ff + STEP_BITS'(1);
      last_step = (idx_next >= total_ff);
      acc_next_x = last_step ? {rpix_x, {FRAC_BITS{1'b0}}} : sum_x;
      acc_next_y = last_step ? {rpix_y, {FRAC_BITS{1'b0}}} : sum_y;
      step_pix_x = last_step ? rpix_x[COORD_BITS-1:0] : trunc_pix(sum_x);
      step_pix_y = last_step ? rpix_y[COORD_BITS-1:0] : trunc_pix(sum_y);
   end

   // Style counters; a zero period acts as one
   always_comb begin
      dot_lim   = (dot_per_ff == '0) ? DOT_BITS'(1) : dot_per_ff;
      dot_sum   = {1'b0, dot_cnt_ff} + (DOT_BITS+1)'(1);
      dot_hit   = (dot_sum >= {1'b0, dot_lim});
      dash_lim  = (dash_per_ff == '0) ? DASH_BITS'(1) : dash_per_ff;
      dash_sum  = {1'b0, dash_cnt_ff} + (DASH_BITS+1)'(1);
      dash_wrap = (dash_sum >= {1'b0, dash_lim});
      dash_off_next = dash_off_ff ^ dash_wrap;
      case (style_ff)
         STYLE_DOTTED: step_plot = dot_hit;
         STYLE_DASHED: step_plot = !dash_off_next;
         default:      step_plot = 1'b1;
      endcase
   end

   // Config and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff    <= STYLE_SIMPLE;
         dot_per_ff  <= DOT_PERIOD_RST;
         dash_per_ff <= DASH_PERIOD_RST;
         acc_x_ff    <= '0;
         acc_y_ff    <= '0;
         inc_x_ff    <= '0;
         inc_y_ff    <= '0;
         idx_ff      <= '0;
         total_ff    <= '0;
         dot_cnt_ff  <= '0;
         dash_cnt_ff <= '0;
         dash_off_ff <= 1'b0;
         active_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_STYLE:  style_ff    <= csr_data[STYLE_BITS-1:0];
               CSR_DOT_PERIOD:  dot_per_ff  <= csr_data[DOT_BITS-1:0];
               CSR_DASH_PERIOD: dash_per_ff <= csr_data[DASH_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.start) begin
            acc_x_ff    <= {x_start[COORD_BITS-1], x_start, {FRAC_BITS{1'b0}}};
            acc_y_ff    <= {y_start[COORD_BITS-1], y_start, {FRAC_BITS{1'b0}}};
            inc_x_ff    <= '0;
            inc_y_ff    <= '0;
            idx_ff      <= '0;
            total_ff    <= {1'b0, len};
            dot_cnt_ff  <= '0;
            dash_cnt_ff <= '0;
            dash_off_ff <= 1'b0;
            active_ff   <= !status.len_zero;
         end else if (cmd.step && active_ff) begin
            acc_x_ff    <= acc_next_x;
            acc_y_ff    <= acc_next_y;
            idx_ff      <= idx_next;
            dot_cnt_ff  <= dot_hit ? '0 : dot_sum[DOT_BITS-1:0];
            dash_cnt_ff <= dash_wrap ? '0 : dash_sum[DASH_BITS-1:0];
            dash_off_ff <= dash_off_next;
            active_ff   <= !last_step;
         end
         if (cmd.div_finish) begin
            inc_x_ff <= neg_x_ff ? -{1'b0, quo_x_ff} : {1'b0, quo_x_ff};
            inc_y_ff <= neg_y_ff ? -{1'b0, quo_y_ff} : {1'b0, quo_y_ff};
         end
      end
   end

   // Divider lanes: load on start, iterate on command
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_x_ff <= dx[COORD_BITS];
         neg_y_ff <= dy[COORD_BITS];
         rem_x_ff <= num_x[NUM_BITS-1:QUO_BITS];
         rem_y_ff <= num_y[NUM_BITS-1:QUO_BITS];
         quo_x_ff <= num_x[QUO_BITS-1:0];
         quo_y_ff <= num_y[QUO_BITS-1:0];
      end else if (cmd.div_step) begin
         rem_x_ff <= ge_x ? diff_x[COORD_BITS-1:0] : trial_x[COORD_BITS-1:0];
         rem_y_ff <= ge_y ? diff_y[COORD_BITS-1:0] : trial_y[COORD_BITS-1:0];
         quo_x_ff <= {quo_x_ff[QUO_BITS-2:0], ge_x};
         quo_y_ff <= {quo_y_ff[QUO_BITS-2:0], ge_y};
      end
   end

   // Capture the result word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.start) begin
            pix_x_ff <= x_start;
            pix_y_ff <= y_start;
            plot_ff  <= 1'b1;
            wide_ff  <= (style_ff == STYLE_THICK);
            last_ff  <= status.len_zero;
            idle_ff  <= 1'b0;
         end else if (active_ff) begin
            pix_x_ff <= step_pix_x;
            pix_y_ff <= step_pix_y;
            plot_ff  <= step_plot;
            wide_ff  <= (style_ff == STYLE_THICK);
            last_ff  <= last_step;
            idle_ff  <= 1'b0;
         end else begin
            pix_x_ff <= trunc_pix(acc_x_ff);
            pix_y_ff <= trunc_pix(acc_y_ff);
            plot_ff  <= 1'b0;
            wide_ff  <= 1'b0;
            last_ff  <= 1'b0;
            idle_ff  <= 1'b1;
         end
      end
   end

   assign pixel_x    = pix_x_ff;
   assign pixel_y    = pix_y_ff;
   assign plotted    = plot_ff;
   assign wide_point = wide_ff;
   assign last_pixel = last_ff;
   assign idle_step  = idle_ff;

endmodule

[sv/styled_dda_line_stepper_unit.sv]
// Top level of the styled line stepper: controller plus datapath.
// Depends on sdls_pkg, sdls_if, sdls_ctrl and sdls_datapath.
//
// Usage: req_ch carries one word per item. action start loads two endpoints
// and returns the start pixel; action step advances one position and returns
// one pixel with plotted, wide_point and last_pixel flags. A step with no
// line in progress returns the held position with idle_step set.
// csr_ch writes line_style (0), dot_period (1), dash_period (2); it is ready
// whenever reset is low and should be written only while no item is in flight.
// Every item yields exactly one rsp_ch word, registered, in the cycle after
// it is accepted. Steps are accepted back to back, one per cycle, while
// rsp_ch is ready. A start runs a restoring divider at one quotient bit per
// cycle on both axes, then a finish state, and no new item is taken until
// both are done, unless the endpoints are equal.
// When rsp_ch stalls the held word stays put; one new item may still be
// accepted in the cycle the held word is taken.
// Reset (synchronous, active high) clears the line, selects simple style,
// dot period 20 and dash period 15, and drops any pending result.
module styled_dda_line_stepper_unit import sdls_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sdls_req_if.sink    req_ch,
   sdls_rsp_if.source  rsp_ch,
   sdls_csr_if.sink    csr_ch
);

   sdls_cmd_type    cmd;
   sdls_status_type status;
   logic            csr_we;
   logic signed [COORD_BITS-1:0] dp_pixel_x, dp_pixel_y;

   // Register writes complete in the cycle they are offered
   assign csr_ch.ready = !reset;
   assign csr_we       = csr_ch.valid && csr_ch.ready;

   sdls_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .status     (status),
      .cmd        (cmd)
   );

   sdls_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .x_start    (req_ch.x_start),
      .y_start    (req_ch.y_start),
      .x_end      (req_ch.x_end),
      .y_end      (req_ch.y_end),
      .csr_we     (csr_we),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .pixel_x    (dp_pixel_x),
      .pixel_y    (dp_pixel_y),
      .plotted    (rsp_ch.plotted),
      .wide_point (rsp_ch.wide_point),
      .last_pixel (rsp_ch.last_pixel),
      .idle_step  (rsp_ch.idle_step)
   );

   assign rsp_ch.pixel_x = dp_pixel_x;
   assign rsp_ch.pixel_y = dp_pixel_y;

endmodule
